[hw/rtl/crcdm_pkg.sv]
// shared types, constants and crc step functions for the dual-mode crc-32 byte engine
// no dependencies

package crcdm_pkg;

    localparam int unsigned CRC_W      = 32;
    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned FLUSH_BYTES = 4;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CRC_W-1:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [CRC_W-1:0] POLY_DEFAULT = 32'h04C1_1DB7;
    localparam logic             MODE_DEFAULT = 1'b0;

    // register indexes on the configuration channel
    localparam logic [CFG_IDX_W-1:0] REG_POLYNOMIAL = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AUG_MODE   = 1'd1;

    // finished-value transfer between the crc stage and the flush pipeline
    typedef struct packed {
        logic             valid;
        logic             aug;
        logic [CRC_W-1:0] value;
    } t_fin;

    // reduction of (top << 24) through eight msb-first shifts
    function automatic logic [CRC_W-1:0] msb_reduce(
        input logic [BYTE_W-1:0] top,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] rem;
        rem = {top, {(CRC_W-BYTE_W){1'b0}}};
        for (int i = 0; i < BYTE_W; i++) begin
            if (rem[CRC_W-1]) begin
                rem = (rem << 1) ^ poly;
            end else begin
                rem = rem << 1;
            end
        end
        return rem;
    endfunction

    function automatic logic [CRC_W-1:0] reflected_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        logic [CRC_W-1:0] rp;
        logic [CRC_W-1:0] r;
        for (int i = 0; i < CRC_W; i++) begin
            rp[i] = poly[CRC_W-1-i];
        end
        r = crc ^ {{(CRC_W-BYTE_W){1'b0}}, data};
        for (int i = 0; i < BYTE_W; i++) begin
            if (r[0]) begin
                r = (r >> 1) ^ rp;
            end else begin
                r = r >> 1;
            end
        end
        return r;
    endfunction

    function automatic logic [CRC_W-1:0] augmented_byte(
        input logic [CRC_W-1:0]  crc,
        input logic [BYTE_W-1:0] data,
        input logic [CRC_W-1:0]  poly
    );
        return {crc[CRC_W-BYTE_W-1:0], data} ^ msb_reduce(crc[CRC_W-1 -: BYTE_W], poly);
    endfunction

endpackage

[hw/rtl/crcdm_flush.sv]
// zero-byte flush pipeline for augmented mode, one flush byte per stage
// depends on crcdm_pkg

module crcdm_flush (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic [crcdm_pkg::CRC_W-1:0]   i_poly,
    input  crcdm_pkg::t_fin               i_fin,
    output crcdm_pkg::t_fin               o_fin
);

    localparam int unsigned NSTG = crcdm_pkg::FLUSH_BYTES;

    logic [NSTG-1:0]               r_vld;
    logic [NSTG-1:0]               r_aug;
    logic [crcdm_pkg::CRC_W-1:0]   r_val [NSTG];
    logic [crcdm_pkg::CRC_W-1:0]   n_val [NSTG];

    always_comb begin
        // reflected results pass through untouched
        n_val[0] = i_fin.aug ? crcdm_pkg::augmented_byte(i_fin.value, '0, i_poly)
                             : i_fin.value;
        for (int k = 1; k < NSTG; k++) begin
            n_val[k] = r_aug[k-1] ? crcdm_pkg::augmented_byte(r_val[k-1], '0, i_poly)
                                  : r_val[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_adv) begin
            r_vld <= {r_vld[NSTG-2:0], i_fin.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_aug <= {r_aug[NSTG-2:0], i_fin.aug};
            for (int k = 0; k < NSTG; k++) begin
                r_val[k] <= n_val[k];
            end
        end
    end

    assign o_fin.valid = r_vld[NSTG-1];
    assign o_fin.aug   = r_aug[NSTG-1];
    assign o_fin.value = r_val[NSTG-1];

endmodule

[hw/rtl/crc32_dual_mode_byte_engine_top.sv]
// top level of the dual-mode crc-32 byte engine: input register, crc register, output register
// depends on crcdm_pkg and crcdm_flush

// Takes one message byte per clock and returns the CRC-32 on the byte marked
// tlast. Reflected mode gives the standard CRC-32 (init all ones, lsb-first,
// final inversion); augmented mode shifts bytes in msb-first and flushes four
// zero bytes. Throughput is one byte per cycle while the output is not stalled,
// set by the crc register feedback, which applies eight bit steps per cycle. A
// result passes through the input register, crc stage, four flush stages and
// output register after its last byte is taken; any stall at the output holds
// the whole pipeline. Configuration writes are taken at once and should only
// arrive while no message is in flight.

module crc32_dual_mode_byte_engine_top #(
    parameter logic [crcdm_pkg::CRC_W-1:0] POLY_RESET = crcdm_pkg::POLY_DEFAULT,
    parameter logic                        MODE_RESET = crcdm_pkg::MODE_DEFAULT
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // input byte stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [7:0]                        s_axis_tdata,   // [7:0] data_byte
    input  logic                              s_axis_tlast,   // last_byte
    input  logic [0:0]                        s_axis_tuser,   // [0] first_byte
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [31:0]                       m_axis_tdata,   // [31:0] crc_value
    // configuration writes
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [crcdm_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [crcdm_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int unsigned CW = crcdm_pkg::CRC_W;
    localparam int unsigned BW = crcdm_pkg::BYTE_W;

    logic [CW-1:0]   r_poly;
    logic            r_aug;

    logic            r_in_vld;
    logic [BW-1:0]   r_in_byte;
    logic            r_in_first;
    logic            r_in_last;

    logic [CW-1:0]   r_crc;
    logic [CW-1:0]   n_crc;
    logic [CW-1:0]   w_crc_base;

    crcdm_pkg::t_fin r_fin;
    crcdm_pkg::t_fin n_fin;
    crcdm_pkg::t_fin w_flush_out;

    logic            r_out_vld;
    logic [CW-1:0]   r_out_crc;
    logic            w_adv;

    // whole pipeline moves unless the output holds a result the sink will not take
    assign w_adv         = !r_out_vld || m_axis_tready;
    assign s_axis_tready = w_adv;
    assign o_cfg_ready   = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_poly <= POLY_RESET;
            r_aug  <= MODE_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                crcdm_pkg::REG_POLYNOMIAL: r_poly <= i_cfg_data[CW-1:0];
                crcdm_pkg::REG_AUG_MODE:   r_aug  <= i_cfg_data[0];
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_adv) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_in_byte  <= s_axis_tdata;
            r_in_first <= s_axis_tuser[0];
            r_in_last  <= s_axis_tlast;
        end
    end

    // crc update for the byte in the input register
    always_comb begin
        w_crc_base = r_in_first ? crcdm_pkg::CRC_INIT : r_crc;
        if (r_aug) begin
            n_crc = crcdm_pkg::augmented_byte(w_crc_base, r_in_byte, r_poly);
        end else begin
            n_crc = crcdm_pkg::reflected_byte(w_crc_base, r_in_byte, r_poly);
        end
        n_fin.valid = r_in_vld && r_in_last;
        n_fin.aug   = r_aug;
        n_fin.value = r_aug ? n_crc : ~n_crc;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_crc       <= crcdm_pkg::CRC_INIT;
            r_fin.valid <= 1'b0;
        end else if (w_adv) begin
            if (r_in_vld) begin
                r_crc <= n_crc;
            end
            r_fin <= n_fin;
        end
    end

    crcdm_flush u_flush (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_poly  (r_poly),
        .i_fin   (r_fin),
        .o_fin   (w_flush_out)
    );

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv) begin
            r_out_vld <= w_flush_out.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_out_crc <= w_flush_out.value;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_crc;

endmodule

[sim/tb.sv]
// self-checking testbench for crc32_dual_mode_byte_engine_top: directed and random byte streams
// under varying polynomial, mode and handshake pressure; expected crcs come from a scoreboard class
// depends on crcdm_pkg and the engine rtl

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 12;
    localparam int PHASE_ITEMS    = 150;
    localparam int PHASES         = 8;

    // running crc of the byte stream and the queue of finished crcs still owed by the block
    class crc_tracker;
        bit [31:0] poly;
        bit        aug;
        bit [31:0] crc_reg;
        bit [31:0] crc_due[$];
        int        errors;

        function new();
            poly    = crcdm_pkg::POLY_DEFAULT;
            aug     = crcdm_pkg::MODE_DEFAULT;
            crc_reg = crcdm_pkg::CRC_INIT;
            errors  = 0;
        endfunction

        task report_mismatch(string msg);
            if (errors < 50) begin
                $display("mismatch at %0t: %s", $realtime, msg);
            end
            errors++;
        endtask

        function void write_reg(bit [crcdm_pkg::CFG_IDX_W-1:0] idx, bit [31:0] value);
            if (idx == crcdm_pkg::REG_POLYNOMIAL) begin
                poly = value;
            end else if (idx == crcdm_pkg::REG_AUG_MODE) begin
                aug = value[0];
            end
        endfunction

        function bit [31:0] top_remainder(bit [7:0] top);
            bit [31:0] rem;
            rem = {top, 24'h0};
            repeat (8) rem = rem[31] ? ((rem << 1) ^ poly) : (rem << 1);
            return rem;
        endfunction

        function bit [31:0] shift_in_byte(bit [31:0] r, bit [7:0] b);
            return {r[23:0], b} ^ top_remainder(r[31:24]);
        endfunction

        function bit [31:0] reflect_in_byte(bit [31:0] r, bit [7:0] b);
            bit [31:0] rpoly;
            for (int i = 0; i < 32; i++) rpoly[i] = poly[31-i];
            r = r ^ {24'h0, b};
            repeat (8) r = r[0] ? ((r >> 1) ^ rpoly) : (r >> 1);
            return r;
        endfunction

        function void take_byte(bit [7:0] b, bit first, bit last);
            bit [31:0] fin;
            if (first) crc_reg = crcdm_pkg::CRC_INIT;
            crc_reg = aug ? shift_in_byte(crc_reg, b) : reflect_in_byte(crc_reg, b);
            if (last) begin
                // augmented result is the register flushed with four zero bytes
                fin = crc_reg;
                if (aug) begin
                    repeat (4) fin = shift_in_byte(fin, 8'h00);
                end else begin
                    fin = ~fin;
                end
                crc_due.push_back(fin);
            end
        endfunction

        task check_crc(bit [31:0] got);
            bit [31:0] want;
            if (crc_due.size() == 0) begin
                report_mismatch($sformatf("crc %08h with nothing outstanding", got));
            end else begin
                want = crc_due.pop_front();
                if (got !== want) begin
                    report_mismatch($sformatf("crc %08h, expected %08h", got, want));
                end
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n;
    logic                             s_axis_tvalid;
    logic                             s_axis_tready;
    logic [7:0]                       s_axis_tdata;   // [7:0] data_byte
    logic                             s_axis_tlast;   // last_byte
    logic [0:0]                       s_axis_tuser;   // [0] first_byte
    logic                             m_axis_tvalid;
    logic                             m_axis_tready;
    logic [31:0]                      m_axis_tdata;   // [31:0] crc_value
    logic                             i_cfg_valid;
    logic                             o_cfg_ready;
    logic [crcdm_pkg::CFG_IDX_W-1:0]  i_cfg_index;
    logic [crcdm_pkg::CFG_DATA_W-1:0] i_cfg_data;

    crc_tracker trk = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    int bytes_left     = 0;
    bit msg_first      = 1'b0;

    crc32_dual_mode_byte_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // transfer monitor and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) trk.check_crc(m_axis_tdata);
            if (s_axis_tvalid && s_axis_tready) begin
                trk.take_byte(s_axis_tdata, s_axis_tuser[0], s_axis_tlast);
            end
            if (i_cfg_valid && o_cfg_ready) trk.write_reg(i_cfg_index, i_cfg_data);
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("tb: errors");
                $finish;
            end
        end
    end

    task send_byte(bit [7:0] b, bit first, bit last);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= first;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // pipeline empty: no crc owed and any trailing unmarked bytes have gone through
    task drain();
        @(negedge i_clk);
        s_axis_tvalid  <= 1'b0;
        recv_stall_pct = 0;
        while (trk.crc_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task write_reg(bit [crcdm_pkg::CFG_IDX_W-1:0] idx, bit [31:0] value);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function bit [7:0] pick_byte();
        case ($urandom_range(9))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // mostly well-formed messages; a message cut by a phase end carries on under new settings
    task random_byte();
        if (bytes_left == 0) begin
            if ($urandom_range(99) < 8) begin
                send_byte(pick_byte(), 1'($urandom), 1'($urandom));
                return;
            end
            bytes_left = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
            msg_first  = ($urandom_range(19) != 0);
        end
        send_byte(pick_byte(), msg_first, bytes_left == 1);
        msg_first = 1'b0;
        bytes_left--;
    endtask

    initial begin
        bit [31:0] phase_poly;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = crcdm_pkg::REG_POLYNOMIAL;
        i_cfg_data    = '0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reflected mode at reset settings: check string, single bytes, unmarked runs
        for (int i = 1; i <= 9; i++) send_byte(8'h30 + 8'(i), i == 1, i == 9);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'hA5, 1'b0, 1'b1);
        send_byte(8'h5A, 1'b1, 1'b0);
        send_byte(8'h3C, 1'b0, 1'b0);
        send_byte(8'hC3, 1'b0, 1'b1);
        drain();
        write_reg(crcdm_pkg::REG_AUG_MODE, 32'd1);
        send_byte(8'h00, 1'b1, 1'b1);
        send_byte(8'hFF, 1'b1, 1'b1);
        send_byte(8'h12, 1'b1, 1'b0);
        send_byte(8'h34, 1'b0, 1'b1);
        // polynomial changed in the middle of a message
        send_byte(8'h80, 1'b1, 1'b0);
        drain();
        write_reg(crcdm_pkg::REG_POLYNOMIAL, 32'hFFFF_FFFF);
        send_byte(8'h01, 1'b0, 1'b1);

        for (int p = 0; p < PHASES; p++) begin
            drain();
            case (p)
                0, 1:    phase_poly = crcdm_pkg::POLY_DEFAULT;
                2, 5:    phase_poly = 32'h0;
                3, 6:    phase_poly = 32'hFFFF_FFFF;
                default: phase_poly = $urandom;
            endcase
            write_reg(crcdm_pkg::REG_POLYNOMIAL, phase_poly);
            write_reg(crcdm_pkg::REG_AUG_MODE, p % 2);
            send_idle_pct  = (p % 4 == 1) ? 56 : (p % 4 == 3) ? 27 : 0;
            recv_stall_pct = (p % 4 == 2) ? 56 : (p % 4 == 3) ? 27 : 0;
            repeat (PHASE_ITEMS) random_byte();
        end

        drain();
        repeat (20) @(posedge i_clk);
        if (trk.crc_due.size() != 0) begin
            trk.report_mismatch($sformatf("%0d crc results never arrived", trk.crc_due.size()));
        end
        if (trk.errors == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule
